[hdl/cds_pkg.sv]
package cds_pkg;

   localparam int MAX_OBS          = 4096;
   localparam int MAX_DIMS         = 4;
   localparam int CLUSTERS_PER_DIM = 256;
   localparam int OBS_AW           = 12;
   localparam int CL_W             = 8;
   localparam int DIM_W            = 2;
   localparam int TAB_AW           = DIM_W + CL_W;
   localparam int TAB_DEPTH        = MAX_DIMS * CLUSTERS_PER_DIM;
   localparam int ACC_W            = 48;

   localparam logic [2:0] REG_ITER_MAX  = 3'd0;
   localparam logic [2:0] REG_NUM_DIMS  = 3'd1;
   localparam logic [2:0] REG_TOLERANCE = 3'd2;
   localparam logic [2:0] REG_COUNT_0   = 3'd3;
   localparam logic [2:0] REG_COUNT_1   = 3'd4;
   localparam logic [2:0] REG_COUNT_2   = 3'd5;
   localparam logic [2:0] REG_COUNT_3   = 3'd6;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_WCLR, S_WOBS, S_WTAB, S_WADD, S_SWEEP, S_UCLR,
      S_AOBS, S_AMUL, S_ATAB, S_AADD, S_DRD, S_DDIV, S_DWAIT,
      S_POBS, S_PTAB, S_PWR, S_NEXT, S_DONE
   } state_type;

   function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W+1:0] v);
      logic signed [ACC_W+1:0] hi;
      logic signed [ACC_W+1:0] lo;
      hi = {3'b000, {(ACC_W-1){1'b1}}};
      lo = {3'b111, {(ACC_W-1){1'b0}}};
      if (v > hi) sat48 = hi[ACC_W-1:0];
      else if (v < lo) sat48 = lo[ACC_W-1:0];
      else sat48 = v[ACC_W-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) sat32 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else sat32 = v[31:0];
   endfunction

endpackage

[hdl/cds_ram.sv]
module cds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cds_div.sv]
module cds_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [47:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [48:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [47:0] dvs_ff, dvs_in;
   logic [48:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff[47:0], quo_ff[63]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/cluster_derivative_solver.sv]
// Gauss-Seidel fixed-effects solver over up to 4096 observations held in
// single-port-read memories. Load words stream in one per cycle while idle;
// a read result passes the memory read register and then the response
// register, and the next read waits until that result has left. A load
// marked last starts the solve, during which no word is accepted: a clear of
// all 1024 weight-sum table entries, a pass over the observations to build
// the weight sums, then per sweep and dimension a clear of its 256 update
// entries, a pass over the observations to accumulate, a division per
// cluster on the 64-step serial divider (skipped when the weight sum is
// zero), and a pass to apply the updates. The solve ends in one status word.
module cluster_derivative_solver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [11:0]        req_read_index,
   input  logic signed [31:0] req_second_deriv,
   input  logic signed [31:0] req_cross_term,
   input  logic signed [31:0] req_start_value,
   input  logic [7:0]         req_cluster_id_0,
   input  logic [7:0]         req_cluster_id_1,
   input  logic [7:0]         req_cluster_id_2,
   input  logic [7:0]         req_cluster_id_3,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_status,
   output logic signed [31:0] rsp_value,
   output logic [11:0]        rsp_value_index,
   output logic               rsp_limit_reached,
   output logic [15:0]        rsp_sweeps_used,
   output logic               rsp_load_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import cds_pkg::*;

   state_type state_ff, state_in;
   logic [12:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0] q_ff, q_in;
   logic [15:0] iter_ff, iter_in;
   logic again_ff, again_in;
   logic [12:0] obs_count_ff, obs_count_in;
   logic ovf_ff, ovf_in;
   logic [11:0] idx_ff, idx_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [48:0] t_ff, t_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_is_status_ff, rsp_is_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [11:0] rsp_value_index_ff, rsp_value_index_in;
   logic rsp_limit_ff, rsp_limit_in;
   logic [15:0] rsp_sweeps_ff, rsp_sweeps_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   logic [15:0] iter_max_ff;
   logic [2:0] num_dims_ff;
   logic [30:0] tolerance_ff;
   logic [8:0] count_ff [MAX_DIMS];

   // observation store ports
   logic obs_we, rs_we, obs_re;
   logic [OBS_AW-1:0] obs_waddr, obs_raddr;
   logic [31:0] rs_wdata;
   logic signed [31:0] w_rd, x_rd, rs_rd;
   logic [31:0] id_rd;
   // table ports
   logic ws_we, ws_re, up_we, up_re;
   logic [TAB_AW-1:0] ws_waddr, ws_raddr, up_waddr, up_raddr;
   logic [ACC_W-1:0] ws_wdata, up_wdata;
   logic signed [ACC_W-1:0] ws_rd, up_rd;

   logic div_start, div_done;
   logic [63:0] div_quo;
   logic [47:0] acc_mag, ws_mag;
   logic [63:0] div_dvd;

   logic [2:0] dims;
   logic [CL_W-1:0] cl_id;
   logic [8:0] cnt_cl;
   logic cl_ok;
   logic q_more;
   logic neg;
   logic [31:0] qclamp;
   logic signed [31:0] u;
   logic [31:0] u_mag;
   logic ws_zero;
   logic req_take;

   cds_ram #(.WIDTH(32), .DEPTH(MAX_OBS)) u_weight (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_waddr), .wr_data(req_second_deriv),
      .rd_en(obs_re), .rd_addr(obs_raddr), .rd_data(w_rd));
   cds_ram #(.WIDTH(32), .DEPTH(MAX_OBS)) u_cross (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_waddr), .wr_data(req_cross_term),
      .rd_en(obs_re), .rd_addr(obs_raddr), .rd_data(x_rd));
   cds_ram #(.WIDTH(32), .DEPTH(MAX_OBS)) u_rsum (
      .clock(clock), .wr_en(rs_we), .wr_addr(obs_waddr), .wr_data(rs_wdata),
      .rd_en(obs_re), .rd_addr(obs_raddr), .rd_data(rs_rd));
   cds_ram #(.WIDTH(32), .DEPTH(MAX_OBS)) u_ids (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_waddr),
      .wr_data({req_cluster_id_3, req_cluster_id_2, req_cluster_id_1, req_cluster_id_0}),
      .rd_en(obs_re), .rd_addr(obs_raddr), .rd_data(id_rd));
   cds_ram #(.WIDTH(ACC_W), .DEPTH(TAB_DEPTH)) u_wsum (
      .clock(clock), .wr_en(ws_we), .wr_addr(ws_waddr), .wr_data(ws_wdata),
      .rd_en(ws_re), .rd_addr(ws_raddr), .rd_data(ws_rd));
   cds_ram #(.WIDTH(ACC_W), .DEPTH(TAB_DEPTH)) u_upd (
      .clock(clock), .wr_en(up_we), .wr_addr(up_waddr), .wr_data(up_wdata),
      .rd_en(up_re), .rd_addr(up_raddr), .rd_data(up_rd));

   cds_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(ws_mag), .done(div_done), .quotient(div_quo));

   always_comb begin
      dims    = (num_dims_ff > 3'd4) ? 3'd4 : num_dims_ff;
      case (q_ff)
         2'd0:    cl_id = id_rd[7:0];
         2'd1:    cl_id = id_rd[15:8];
         2'd2:    cl_id = id_rd[23:16];
         default: cl_id = id_rd[31:24];
      endcase
      cnt_cl  = (count_ff[q_ff] > 9'd256) ? 9'd256 : count_ff[q_ff];
      cl_ok   = ({1'b0, cl_id} < cnt_cl) && ({1'b0, q_ff} < dims);
      q_more  = ({1'b0, q_ff} + 3'd1) < dims;
      acc_mag = up_rd[ACC_W-1] ? 48'(-up_rd) : 48'(up_rd);
      ws_mag  = ws_rd[ACC_W-1] ? 48'(-ws_rd) : 48'(ws_rd);
      div_dvd = {acc_mag, 16'h0000};
      ws_zero = (ws_rd == '0);
      neg     = (up_rd[ACC_W-1] == ws_rd[ACC_W-1]);
      qclamp  = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : div_quo[31:0];
      if (ws_zero) u = '0;
      else if (neg) u = -$signed(qclamp);
      else u = (qclamp == 32'h8000_0000) ? 32'sh7FFF_FFFF : $signed(qclamp);
      u_mag   = u[31] ? 32'(-u) : 32'(u);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      iter_in = iter_ff;
      again_in = again_ff;
      obs_count_in = obs_count_ff;
      ovf_in = ovf_ff;
      idx_in = idx_ff;
      prod_in = prod_ff;
      t_in = t_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_is_status_in = rsp_is_status_ff;
      rsp_value_in = rsp_value_ff;
      rsp_value_index_in = rsp_value_index_ff;
      rsp_limit_in = rsp_limit_ff;
      rsp_sweeps_in = rsp_sweeps_ff;
      rsp_ovf_in = rsp_ovf_ff;
      obs_we = 1'b0;
      rs_we = 1'b0;
      obs_re = 1'b0;
      obs_waddr = cnt_ff[OBS_AW-1:0];
      obs_raddr = cnt_ff[OBS_AW-1:0];
      rs_wdata = sat32(33'(rs_rd) + 33'($signed(up_rd[31:0])));
      ws_we = 1'b0;
      ws_re = 1'b0;
      ws_waddr = {q_ff, cl_id};
      ws_raddr = {q_ff, cl_id};
      ws_wdata = sat48(50'(ws_rd) + 50'(w_rd));
      up_we = 1'b0;
      up_re = 1'b0;
      up_waddr = {q_ff, cl_id};
      up_raddr = {q_ff, cl_id};
      up_wdata = sat48(50'(up_rd) + 50'(t_ff));
      div_start = 1'b0;
      req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || !req_command);
      req_take = req_valid && req_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_command) begin
                  obs_re = 1'b1;
                  obs_raddr = req_read_index;
                  idx_in = req_read_index;
                  state_in = S_READ;
               end else begin
                  obs_waddr = obs_count_ff[OBS_AW-1:0];
                  if (!obs_count_ff[OBS_AW]) begin
                     obs_we = 1'b1;
                     rs_we = 1'b1;
                     rs_wdata = req_start_value;
                     obs_count_in = obs_count_ff + 13'd1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_last) begin
                     cnt_in = '0;
                     q_in = '0;
                     iter_in = '0;
                     again_in = 1'b1;
                     state_in = S_WCLR;
                  end
               end
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_is_status_in = 1'b0;
            rsp_value_in = rs_rd;
            rsp_value_index_in = idx_ff;
            rsp_limit_in = 1'b0;
            rsp_sweeps_in = '0;
            rsp_ovf_in = 1'b0;
            state_in = S_IDLE;
         end
         S_WCLR: begin
            ws_we = 1'b1;
            ws_waddr = cnt_ff[TAB_AW-1:0];
            ws_wdata = '0;
            if (cnt_ff[TAB_AW-1:0] == TAB_AW'(TAB_DEPTH - 1)) begin
               cnt_in = '0;
               state_in = S_WOBS;
            end else begin
               cnt_in = cnt_ff + 13'd1;
            end
         end
         S_WOBS: begin
            q_in = '0;
            if (cnt_ff == obs_count_ff) begin
               state_in = S_SWEEP;
            end else begin
               obs_re = 1'b1;
               state_in = S_WTAB;
            end
         end
         S_WTAB, S_WADD: begin
            if (state_ff == S_WADD) begin
               ws_we = 1'b1;
            end
            if (state_ff == S_WTAB && cl_ok) begin
               ws_re = 1'b1;
               state_in = S_WADD;
            end else if (q_more) begin
               q_in = q_ff + DIM_W'(1);
               state_in = S_WTAB;
            end else begin
               cnt_in = cnt_ff + 13'd1;
               state_in = S_WOBS;
            end
         end
         S_SWEEP: begin
            if (again_ff && iter_ff < iter_max_ff) begin
               iter_in = iter_ff + 16'd1;
               again_in = 1'b0;
               q_in = '0;
               cnt_in = '0;
               // no dimension in use: the sweep is empty
               state_in = (dims == 3'd0) ? S_SWEEP : S_UCLR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_UCLR: begin
            up_we = 1'b1;
            up_waddr = {q_ff, cnt_ff[CL_W-1:0]};
            up_wdata = '0;
            if (cnt_ff[CL_W-1:0] == CL_W'(CLUSTERS_PER_DIM - 1)) begin
               cnt_in = '0;
               state_in = S_AOBS;
            end else begin
               cnt_in = cnt_ff + 13'd1;
            end
         end
         S_AOBS: begin
            if (cnt_ff == obs_count_ff) begin
               cnt_in = '0;
               state_in = S_DRD;
            end else begin
               obs_re = 1'b1;
               state_in = S_AMUL;
            end
         end
         S_AMUL: begin
            prod_in = rs_rd * w_rd;
            if (cl_ok) begin
               up_re = 1'b1;
               state_in = S_ATAB;
            end else begin
               cnt_in = cnt_ff + 13'd1;
               state_in = S_AOBS;
            end
         end
         S_ATAB: begin
            // arithmetic shift floors toward minus infinity
            t_in = 49'(x_rd) + 49'(prod_ff >>> 16);
            state_in = S_AADD;
         end
         S_AADD: begin
            up_we = 1'b1;
            cnt_in = cnt_ff + 13'd1;
            state_in = S_AOBS;
         end
         S_DRD: begin
            up_re = 1'b1;
            ws_re = 1'b1;
            up_raddr = {q_ff, cnt_ff[CL_W-1:0]};
            ws_raddr = {q_ff, cnt_ff[CL_W-1:0]};
            state_in = S_DDIV;
         end
         S_DDIV: begin
            div_start = !ws_zero;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (ws_zero || div_done) begin
               up_we = 1'b1;
               up_waddr = {q_ff, cnt_ff[CL_W-1:0]};
               up_wdata = ACC_W'(u);
               if (u_mag > {1'b0, tolerance_ff}) begin
                  again_in = 1'b1;
               end
               if (cnt_ff[CL_W-1:0] == CL_W'(CLUSTERS_PER_DIM - 1)) begin
                  cnt_in = '0;
                  state_in = S_POBS;
               end else begin
                  cnt_in = cnt_ff + 13'd1;
                  state_in = S_DRD;
               end
            end
         end
         S_POBS: begin
            if (cnt_ff == obs_count_ff) begin
               state_in = S_NEXT;
            end else begin
               obs_re = 1'b1;
               state_in = S_PTAB;
            end
         end
         S_PTAB: begin
            if (cl_ok) begin
               up_re = 1'b1;
               state_in = S_PWR;
            end else begin
               cnt_in = cnt_ff + 13'd1;
               state_in = S_POBS;
            end
         end
         S_PWR: begin
            rs_we = 1'b1;
            cnt_in = cnt_ff + 13'd1;
            state_in = S_POBS;
         end
         S_NEXT: begin
            cnt_in = '0;
            if (q_more) begin
               q_in = q_ff + DIM_W'(1);
               state_in = S_UCLR;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_is_status_in = 1'b1;
               rsp_value_in = '0;
               rsp_value_index_in = '0;
               rsp_limit_in = (iter_ff == iter_max_ff);
               rsp_sweeps_in = iter_ff;
               rsp_ovf_in = ovf_ff;
               obs_count_in = '0;
               ovf_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         q_ff <= '0;
         iter_ff <= '0;
         again_ff <= 1'b0;
         obs_count_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         q_ff <= q_in;
         iter_ff <= iter_in;
         again_ff <= again_in;
         obs_count_ff <= obs_count_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      prod_ff <= prod_in;
      t_ff <= t_in;
      rsp_is_status_ff <= rsp_is_status_in;
      rsp_value_ff <= rsp_value_in;
      rsp_value_index_ff <= rsp_value_index_in;
      rsp_limit_ff <= rsp_limit_in;
      rsp_sweeps_ff <= rsp_sweeps_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_max_ff <= 16'd1000;
         num_dims_ff <= 3'd1;
         tolerance_ff <= 31'd66;
         for (int k = 0; k < MAX_DIMS; k++) begin
            count_ff[k] <= 9'd1;
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_ITER_MAX:  iter_max_ff <= csr_data[15:0];
            REG_NUM_DIMS:  num_dims_ff <= csr_data[2:0];
            REG_TOLERANCE: tolerance_ff <= csr_data[30:0];
            REG_COUNT_0:   count_ff[0] <= csr_data[8:0];
            REG_COUNT_1:   count_ff[1] <= csr_data[8:0];
            REG_COUNT_2:   count_ff[2] <= csr_data[8:0];
            REG_COUNT_3:   count_ff[3] <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_status = rsp_is_status_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_value_index = rsp_value_index_ff;
   assign rsp_limit_reached = rsp_limit_ff;
   assign rsp_sweeps_used = rsp_sweeps_ff;
   assign rsp_load_overflow = rsp_ovf_ff;

endmodule
